// ===== sv/fcfs_pkg.sv =====
// Package: shared constants, codes, entry types and sequencer states.
`default_nettype none
package fcfs_pkg;

  localparam int unsigned MAX_PROCS_DEF = 64;
  localparam int unsigned MAX_KILLS_DEF = 64;

  typedef enum logic [1:0] {
    FUNC_LOAD_PROC = 2'd0,
    FUNC_LOAD_KILL = 2'd1,
    FUNC_RUN       = 2'd2,
    FUNC_NONE      = 2'd3
  } func_e;

  typedef struct packed {
    logic [15:0] pid;
    logic [15:0] burst;
    logic [15:0] io_after;
    logic [15:0] io_dur;
  } proc_t;

  typedef struct packed {
    logic [15:0] pid;
    logic [31:0] tick;
  } kill_t;

  typedef struct packed {
    logic        killed;
    logic [31:0] comp;
    logic [31:0] wait_v;
  } outc_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BLK,
    S_BLKU,
    S_DISP,
    S_RDY,
    S_PT,
    S_KILL,
    S_EXEC,
    S_EMIT,
    S_EMW,
    S_EMH
  } state_e;

endpackage
`default_nettype wire

// ===== sv/fcfs_if.sv =====
// Interfaces: request channel and result channel.
`default_nettype none
interface fcfs_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] pid;
  logic [15:0] burst_len;
  logic [15:0] io_after;
  logic [15:0] io_len;
  logic [31:0] kill_time;
  modport source (output valid, func, pid, burst_len, io_after, io_len, kill_time,
                  input ready);
  modport sink (input valid, func, pid, burst_len, io_after, io_len, kill_time,
                output ready);
endinterface

interface fcfs_rsp_if;
  logic               valid;
  logic               ready;
  logic [15:0]        proc_id;
  logic               killed;
  logic [31:0]        completion_tick;
  logic [31:0]        turnaround;
  logic signed [31:0] wait_ticks;
  logic               last;
  modport source (output valid, proc_id, killed, completion_tick, turnaround, wait_ticks,
                  last, input ready);
  modport sink (input valid, proc_id, killed, completion_tick, turnaround, wait_ticks,
                last, output ready);
endinterface
`default_nettype wire

// ===== sv/fcfs_ram.sv =====
// Generic simple dual-port RAM, one write port, registered read.
`default_nettype none
module fcfs_ram #(
  parameter int unsigned W = 8,
  parameter int unsigned D = 64,
  localparam int unsigned AW = (D > 1) ? $clog2(D) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [W-1:0]  wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [W-1:0]  rdata_o
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ===== sv/fcfs_scheduler_with_io_and_kill.sv =====
// Top level: FCFS scheduler with one I/O burst per process and kill events.
//  channel | dir | handshake         | carries
//  req_i   | in  | valid/ready       | func, pid, burst_len, io_after, io_len, kill_time
//  rsp_o   | out | valid/ready       | proc_id, killed, completion_tick, turnaround,
//          |     |                   | wait_ticks, last
// Load requests are accepted while idle. A run walks tick by tick through one sequencer:
// each tick updates every blocked process, dispatches, scans the kill table and executes;
// then each result is read out and held until rsp_o.ready takes it.
// Reset clears counters and control only; the tables are valid once written.
// req_i is not ready from the start of a run until its last result is taken.
`default_nettype none
module fcfs_scheduler_with_io_and_kill #(
  parameter int unsigned MAX_PROCS = fcfs_pkg::MAX_PROCS_DEF,
  parameter int unsigned MAX_KILLS = fcfs_pkg::MAX_KILLS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  fcfs_req_if.sink    req_i,
  fcfs_rsp_if.source  rsp_o
);
  localparam int unsigned PW  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int unsigned RD  = 1 << PW;
  localparam int unsigned CW  = $clog2(MAX_PROCS + 1);
  localparam int unsigned KW  = (MAX_KILLS > 1) ? $clog2(MAX_KILLS) : 1;
  localparam int unsigned KCW = $clog2(MAX_KILLS + 1);
  localparam int unsigned RW  = PW + 16;
  localparam int unsigned BW  = PW + 32;

  fcfs_pkg::state_e state_q, state_d;

  logic [31:0]    t_q, t_d;
  logic [CW-1:0]  ltot_q, ltot_d, n_q, n_d, done_q, done_d, nxt_q, nxt_d;
  logic [CW-1:0]  rcnt_q, rcnt_d, wcnt_q, wcnt_d, bleft_q, bleft_d, eidx_q, eidx_d;
  logic [KCW-1:0] ktot_q, ktot_d, kidx_q, kidx_d;
  logic [PW-1:0]  rhead_q, rhead_d, whead_q, whead_d, cur_q, cur_d;
  logic [15:0]    exec_q, exec_d;
  logic           running_q, running_d, kv_q, kv_d, hit_q, hit_d;
  fcfs_pkg::proc_t cp_q, cp_d;

  // output register
  logic        ov_q, ov_d, ld_out;

  // memory ports
  logic            p_we;
  logic [PW-1:0]   p_ra;
  fcfs_pkg::proc_t p_wd, p_rd;
  logic            k_we;
  fcfs_pkg::kill_t k_wd, k_rd;
  logic            o_we;
  fcfs_pkg::outc_t o_wd, o_rd;
  logic            r_we;
  logic [PW-1:0]   r_ra;
  logic [RW-1:0]   r_wd, r_rd;
  logic            b_we;
  logic [BW-1:0]   b_wd, b_rd;

  logic          fire;
  logic [16:0]   e1;
  logic [16:0]   sub_a;
  logic [15:0]   brem;

  assign fire = req_i.valid && req_i.ready;
  assign e1   = {1'b0, exec_q} + 17'd1;
  assign brem = b_rd[15:0] - 16'd1;

  fcfs_ram #(.W($bits(fcfs_pkg::proc_t)), .D(MAX_PROCS)) u_ptab (
    .clk_i, .we_i(p_we), .waddr_i(ltot_q[PW-1:0]), .wdata_i(p_wd),
    .raddr_i(p_ra), .rdata_o(p_rd));

  fcfs_ram #(.W($bits(fcfs_pkg::kill_t)), .D(MAX_KILLS)) u_ktab (
    .clk_i, .we_i(k_we), .waddr_i(ktot_q[KW-1:0]), .wdata_i(k_wd),
    .raddr_i(kidx_q[KW-1:0]), .rdata_o(k_rd));

  fcfs_ram #(.W($bits(fcfs_pkg::outc_t)), .D(MAX_PROCS)) u_outc (
    .clk_i, .we_i(o_we), .waddr_i(cur_q), .wdata_i(o_wd),
    .raddr_i(eidx_q[PW-1:0]), .rdata_o(o_rd));

  // ready ring entries: {index, executed ticks}
  fcfs_ram #(.W(RW), .D(RD)) u_ready (
    .clk_i, .we_i(r_we), .waddr_i(rhead_q + rcnt_q[PW-1:0]), .wdata_i(r_wd),
    .raddr_i(r_ra), .rdata_o(r_rd));

  // blocked ring entries: {index, executed ticks, I/O ticks left}
  fcfs_ram #(.W(BW), .D(RD)) u_blk (
    .clk_i, .we_i(b_we), .waddr_i(whead_q + wcnt_q[PW-1:0]), .wdata_i(b_wd),
    .raddr_i(whead_q), .rdata_o(b_rd));

  assign p_wd = '{pid: req_i.pid, burst: req_i.burst_len, io_after: req_i.io_after,
                  io_dur: req_i.io_len};
  assign k_wd = '{pid: req_i.pid, tick: req_i.kill_time};
  assign r_ra = rhead_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= fcfs_pkg::S_IDLE;
      t_q       <= '0;
      ltot_q    <= '0;
      ktot_q    <= '0;
      n_q       <= '0;
      done_q    <= '0;
      nxt_q     <= '0;
      rcnt_q    <= '0;
      wcnt_q    <= '0;
      bleft_q   <= '0;
      eidx_q    <= '0;
      kidx_q    <= '0;
      rhead_q   <= '0;
      whead_q   <= '0;
      running_q <= 1'b0;
      kv_q      <= 1'b0;
      hit_q     <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      t_q       <= t_d;
      ltot_q    <= ltot_d;
      ktot_q    <= ktot_d;
      n_q       <= n_d;
      done_q    <= done_d;
      nxt_q     <= nxt_d;
      rcnt_q    <= rcnt_d;
      wcnt_q    <= wcnt_d;
      bleft_q   <= bleft_d;
      eidx_q    <= eidx_d;
      kidx_q    <= kidx_d;
      rhead_q   <= rhead_d;
      whead_q   <= whead_d;
      running_q <= running_d;
      kv_q      <= kv_d;
      hit_q     <= hit_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    exec_q <= exec_d;
    cp_q   <= cp_d;
    if (ld_out) begin
      rsp_o.proc_id         <= p_rd.pid;
      rsp_o.killed          <= o_rd.killed;
      rsp_o.completion_tick <= o_rd.comp;
      rsp_o.turnaround      <= o_rd.comp;
      rsp_o.wait_ticks      <= o_rd.wait_v;
      rsp_o.last            <= (eidx_q + CW'(1)) == n_q;
    end
  end

  assign rsp_o.valid = ov_q;
  assign req_i.ready = (state_q == fcfs_pkg::S_IDLE);

  always_comb begin
    state_d   = state_q;
    t_d       = t_q;
    ltot_d    = ltot_q;
    ktot_d    = ktot_q;
    n_d       = n_q;
    done_d    = done_q;
    nxt_d     = nxt_q;
    rcnt_d    = rcnt_q;
    wcnt_d    = wcnt_q;
    bleft_d   = bleft_q;
    eidx_d    = eidx_q;
    kidx_d    = kidx_q;
    rhead_d   = rhead_q;
    whead_d   = whead_q;
    running_d = running_q;
    kv_d      = kv_q;
    hit_d     = hit_q;
    cur_d     = cur_q;
    exec_d    = exec_q;
    cp_d      = cp_q;
    ov_d      = ov_q;
    ld_out    = 1'b0;
    p_we      = 1'b0;
    k_we      = 1'b0;
    o_we      = 1'b0;
    r_we      = 1'b0;
    b_we      = 1'b0;
    p_ra      = eidx_q[PW-1:0];
    r_wd      = {b_rd[BW-1:32], b_rd[31:16]};
    b_wd      = {b_rd[BW-1:16], brem};
    sub_a     = {1'b0, exec_q} + {1'b0, cp_q.io_dur};
    o_wd      = '{killed: 1'b1, comp: t_q, wait_v: t_q - {15'd0, sub_a}};

    case (state_q)
      fcfs_pkg::S_IDLE: begin
        if (fire) begin
          case (fcfs_pkg::func_e'(req_i.func))
            fcfs_pkg::FUNC_LOAD_PROC: begin
              if (ltot_q < CW'(MAX_PROCS)) begin
                p_we   = 1'b1;
                ltot_d = ltot_q + CW'(1);
              end
            end
            fcfs_pkg::FUNC_LOAD_KILL: begin
              if (ktot_q < KCW'(MAX_KILLS)) begin
                k_we   = 1'b1;
                ktot_d = ktot_q + KCW'(1);
              end
            end
            fcfs_pkg::FUNC_RUN: begin
              t_d = '0;
              if (ltot_q != '0) begin
                n_d       = ltot_q;
                done_d    = '0;
                nxt_d     = '0;
                rhead_d   = '0;
                rcnt_d    = '0;
                whead_d   = '0;
                wcnt_d    = '0;
                bleft_d   = '0;
                running_d = 1'b0;
                state_d   = fcfs_pkg::S_BLK;
              end
            end
            default: ;
          endcase
        end
      end
      fcfs_pkg::S_BLK: begin
        // ring read at whead is under way
        if (bleft_q == '0) state_d = fcfs_pkg::S_DISP;
        else               state_d = fcfs_pkg::S_BLKU;
      end
      fcfs_pkg::S_BLKU: begin
        whead_d = whead_q + PW'(1);
        bleft_d = bleft_q - CW'(1);
        if (brem == '0) begin
          r_we   = 1'b1;
          rcnt_d = rcnt_q + CW'(1);
          wcnt_d = wcnt_q - CW'(1);
        end else begin
          // rotate to tail; tail address is unchanged by the pop
          b_we = 1'b1;
        end
        state_d = fcfs_pkg::S_BLK;
      end
      fcfs_pkg::S_DISP: begin
        kidx_d = '0;
        kv_d   = 1'b0;
        hit_d  = 1'b0;
        if (running_q) begin
          state_d = fcfs_pkg::S_KILL;
        end else if (nxt_q < n_q) begin
          // processes never dispatched come before anything in the ring
          cur_d   = nxt_q[PW-1:0];
          exec_d  = '0;
          p_ra    = nxt_q[PW-1:0];
          nxt_d   = nxt_q + CW'(1);
          state_d = fcfs_pkg::S_PT;
        end else if (rcnt_q != '0) begin
          rhead_d = rhead_q + PW'(1);
          rcnt_d  = rcnt_q - CW'(1);
          state_d = fcfs_pkg::S_RDY;
        end else begin
          state_d = fcfs_pkg::S_EXEC;
        end
      end
      fcfs_pkg::S_RDY: begin
        cur_d   = r_rd[RW-1:16];
        exec_d  = r_rd[15:0];
        p_ra    = r_rd[RW-1:16];
        state_d = fcfs_pkg::S_PT;
      end
      fcfs_pkg::S_PT: begin
        cp_d      = p_rd;
        running_d = 1'b1;
        state_d   = fcfs_pkg::S_KILL;
      end
      fcfs_pkg::S_KILL: begin
        kv_d = 1'b0;
        if (kv_q && (k_rd.pid == cp_q.pid) && (k_rd.tick == t_q)) begin
          hit_d   = 1'b1;
          state_d = fcfs_pkg::S_EXEC;
        end else if (kidx_q < ktot_q) begin
          kidx_d = kidx_q + KCW'(1);
          kv_d   = 1'b1;
        end else if (!kv_q) begin
          state_d = fcfs_pkg::S_EXEC;
        end
      end
      fcfs_pkg::S_EXEC: begin
        if (running_q) begin
          if (hit_q) begin
            o_we      = 1'b1;
            running_d = 1'b0;
            done_d    = done_q + CW'(1);
          end else if (e1 >= {1'b0, cp_q.burst}) begin
            sub_a     = {1'b0, cp_q.burst} + {1'b0, cp_q.io_dur};
            o_wd      = '{killed: 1'b0, comp: t_q + 32'd1,
                          wait_v: t_q + 32'd1 - {15'd0, sub_a}};
            o_we      = 1'b1;
            running_d = 1'b0;
            done_d    = done_q + CW'(1);
          end else if ((e1[15:0] == cp_q.io_after) && (cp_q.io_dur != '0)) begin
            b_wd      = {cur_q, e1[15:0], cp_q.io_dur};
            b_we      = 1'b1;
            wcnt_d    = wcnt_q + CW'(1);
            running_d = 1'b0;
          end else begin
            exec_d = e1[15:0];
          end
        end
        t_d     = t_q + 32'd1;
        bleft_d = wcnt_d;
        if (done_d == n_q) begin
          eidx_d  = '0;
          state_d = fcfs_pkg::S_EMIT;
        end else begin
          state_d = fcfs_pkg::S_BLK;
        end
      end
      fcfs_pkg::S_EMIT: begin
        state_d = fcfs_pkg::S_EMW;
      end
      fcfs_pkg::S_EMW: begin
        ld_out  = 1'b1;
        ov_d    = 1'b1;
        state_d = fcfs_pkg::S_EMH;
      end
      fcfs_pkg::S_EMH: begin
        if (rsp_o.ready) begin
          ov_d   = 1'b0;
          eidx_d = eidx_q + CW'(1);
          if ((eidx_q + CW'(1)) == n_q) state_d = fcfs_pkg::S_IDLE;
          else                          state_d = fcfs_pkg::S_EMIT;
        end
      end
      default: state_d = fcfs_pkg::S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== sv/fcfs_checker.sv =====
// Checker on the top level ports, bound to the top level.
`default_nettype none
module fcfs_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [1:0]  in_func,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_comp,
  input wire logic [31:0] out_turn,
  input wire logic        out_last
);
  // a pending result holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_comp) && $stable(out_last))
    else $error("result changed while stalled");

  // no request taken while results go out
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready && out_valid))
    else $error("request accepted during result output");

  // a load never produces a result
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && (in_func != fcfs_pkg::FUNC_RUN) |=> !out_valid)
    else $error("result after a load request");

  // the final result closes the run
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && out_last |=> !out_valid && in_ready)
    else $error("activity after final result");

  a_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_turn == out_comp)
    else $error("turnaround differs from completion tick");
endmodule

bind fcfs_scheduler_with_io_and_kill fcfs_checker u_fcfs_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (req_i.valid),
  .in_ready  (req_i.ready),
  .in_func   (req_i.func),
  .out_valid (rsp_o.valid),
  .out_ready (rsp_o.ready),
  .out_comp  (rsp_o.completion_tick),
  .out_turn  (rsp_o.turnaround),
  .out_last  (rsp_o.last)
);
`default_nettype wire
